// ----- design/fnps_pkg.sv -----
package fnps_pkg;

   localparam int COUNT_W   = 7;
   localparam int PRIME_W   = 10;
   localparam int MAX_COUNT = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_CHECK,
      ST_FLUSH,
      ST_CLEAR,
      ST_LAST,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic start;
      logic fill_wr;
      logic idx_inc;
      logic idx_clr;
      logic mult_load;
      logic clr_wr;
      logic pend_load;
      logic pend_clr;
      logic emit;
      logic emit_cur;
      logic emit_last;
      logic emit_oor;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_last;
      logic idx_end;
      logic mark;
      logic pend_valid;
      logic final_count;
      logic mult_done;
      logic out_free;
   } status_type;

endpackage

// ----- design/fnps_ctrl.sv -----
module fnps_ctrl
   import fnps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (!status.count_zero) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (status.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_READ;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_READ: begin
            if (status.idx_end) begin
               state_in = status.pend_valid ? ST_FINAL : ST_IDLE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.mark) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_READ;
            end else if (status.pend_valid) begin
               state_in = ST_FLUSH;
            end else if (status.final_count) begin
               state_in = ST_LAST;
            end else begin
               cmd.pend_load = 1'b1;
               cmd.mult_load = 1'b1;
               state_in      = ST_CLEAR;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.pend_clr = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CLEAR: begin
            if (status.mult_done) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_READ;
            end else begin
               cmd.clr_wr = 1'b1;
            end
         end
         ST_LAST: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_cur  = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.emit_oor  = 1'b1;
               cmd.pend_clr  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/fnps_dpath.sv -----
module fnps_dpath
   import fnps_pkg::*;
#(
   parameter int SIEVE_SIZE = 512
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] req_count_wanted,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PRIME_W-1:0] rsp_prime_value,
   output logic               rsp_is_last,
   output logic               rsp_out_of_room
);

   localparam int IW = $clog2(SIEVE_SIZE);
   localparam int VW = $clog2(SIEVE_SIZE + 2);
   localparam int MW = VW + 1;

   logic               marks_ff [SIEVE_SIZE];
   logic               mark_ff;
   logic [VW-1:0]      idx_ff;
   logic [MW-1:0]      mult_ff;
   logic [COUNT_W-1:0] found_ff;
   logic [COUNT_W-1:0] wanted_ff;
   logic [PRIME_W-1:0] pend_ff;
   logic               pend_valid_ff;
   logic               rsp_valid_ff;
   logic [PRIME_W-1:0] rsp_prime_ff;
   logic               rsp_last_ff;
   logic               rsp_oor_ff;

   logic [PRIME_W-1:0] cur_prime;
   logic [COUNT_W-1:0] wanted_in;
   logic [IW-1:0]      waddr;
   logic               we;
   logic               wdata;

   assign cur_prime = PRIME_W'(idx_ff + VW'(2));
   assign wanted_in = (req_count_wanted > COUNT_W'(MAX_COUNT)) ?
                      COUNT_W'(MAX_COUNT) : req_count_wanted;
   assign we    = cmd.fill_wr | cmd.clr_wr;
   assign wdata = cmd.fill_wr;
   assign waddr = cmd.fill_wr ? idx_ff[IW-1:0] : mult_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         marks_ff[waddr] <= wdata;
      end
      mark_ff <= marks_ff[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff    <= '0;
         found_ff  <= '0;
         wanted_ff <= wanted_in;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + VW'(1);
         end
         if (cmd.pend_load) begin
            found_ff <= found_ff + COUNT_W'(1);
         end
      end
      if (cmd.mult_load) begin
         mult_ff <= (MW'(idx_ff) << 1) + MW'(2);
      end else if (cmd.clr_wr) begin
         mult_ff <= mult_ff + MW'(idx_ff) + MW'(2);
      end
      if (cmd.pend_load) begin
         pend_ff <= cur_prime;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.pend_load) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.pend_clr || cmd.start) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_prime_ff <= cmd.emit_cur ? cur_prime : pend_ff;
         rsp_last_ff  <= cmd.emit_last;
         rsp_oor_ff   <= cmd.emit_oor;
      end
   end

   always_comb begin
      status.count_zero  = (req_count_wanted == '0);
      status.idx_last    = (idx_ff == VW'(SIEVE_SIZE - 1));
      status.idx_end     = (idx_ff == VW'(SIEVE_SIZE));
      status.mark        = mark_ff;
      status.pend_valid  = pend_valid_ff;
      status.final_count = ((found_ff + COUNT_W'(1)) == wanted_ff);
      status.mult_done   = (mult_ff >= MW'(SIEVE_SIZE));
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_prime_ff;
   assign rsp_is_last     = rsp_last_ff;
   assign rsp_out_of_room = rsp_oor_ff;

endmodule

// ----- design/first_n_primes_sieve_unit.sv -----
// Sieve of Eratosthenes over a table of SIEVE_SIZE marks for the numbers 2 to
// SIEVE_SIZE+1. One request beat carries the count of primes wanted (capped at
// 64). The primes come out in ascending order. The final one is flagged last,
// and also flagged out of room if the table ended first. A count of zero yields
// no beats. The block works on one request at a time. A request is accepted,
// then the whole table is set. After that each candidate is read and checked,
// and each multiple of a found prime is cleared. Each prime found can also
// bring the flush of the prime before it, a second check, and the end of its
// clearing pass. Setting and clearing share the single write port of the mark
// memory. The result side can stall the flushes and the final beat.
// A new request is taken once the last beat of the previous one is loaded.
module first_n_primes_sieve_unit
   import fnps_pkg::*;
#(
   parameter int SIEVE_SIZE = 512
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COUNT_W-1:0] req_count_wanted,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PRIME_W-1:0] rsp_prime_value,
   output logic               rsp_is_last,
   output logic               rsp_out_of_room
);

   cmd_type    cmd;
   status_type status;

   fnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fnps_dpath #(
      .SIEVE_SIZE (SIEVE_SIZE)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_count_wanted (req_count_wanted),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prime_value  (rsp_prime_value),
      .rsp_is_last      (rsp_is_last),
      .rsp_out_of_room  (rsp_out_of_room)
   );

`ifndef SYNTHESIS
   a_zero_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_count_wanted == '0) |=> req_ready)
      else $error("zero count left idle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_count_wanted != '0) |=> !req_ready)
      else $error("request accepted while sieve busy");

   a_oor_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_room) |-> rsp_is_last)
      else $error("out of room on a beat that is not last");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> !$changed(rsp_prime_value))
      else $error("result overwritten before taken");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench
   import fnps_pkg::*;
();

   localparam int SIEVE_SIZE = 512;
   localparam int N_DIRECTED = 20;
   localparam int N_RANDOM   = 130;

   typedef struct packed {
      logic [PRIME_W-1:0] value;
      logic               last;
      logic               oor;
   } prime_beat_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               typed;
      logic               has_beat;
      prime_beat_type     beat;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [COUNT_W-1:0] req_count_wanted;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [PRIME_W-1:0] rsp_prime_value;
   logic               rsp_is_last;
   logic               rsp_out_of_room;

   prime_beat_type pending_primes [$];
   int             mismatches = 0;
   bit             req_calm   = 1'b0;
   bit             rsp_calm   = 1'b0;

   // shadow of the sieve marks
   logic           sieve_marks [SIEVE_SIZE];

   // rows with a typed beat expect exactly that one beat (or none)
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{7'd1,   1'b1, 1'b1, '{10'd2, 1'b1, 1'b0}},
      '{7'd0,   1'b1, 1'b0, '0},
      '{7'd2,   1'b0, 1'b0, '0},
      '{7'd3,   1'b0, 1'b0, '0},
      '{7'd64,  1'b0, 1'b0, '0},
      '{7'd65,  1'b0, 1'b0, '0},
      '{7'd127, 1'b0, 1'b0, '0},
      '{7'd0,   1'b1, 1'b0, '0},
      '{7'd63,  1'b0, 1'b0, '0},
      '{7'd100, 1'b0, 1'b0, '0},
      '{7'd1,   1'b1, 1'b1, '{10'd2, 1'b1, 1'b0}},
      '{7'd32,  1'b0, 1'b0, '0},
      '{7'd16,  1'b0, 1'b0, '0},
      '{7'd8,   1'b0, 1'b0, '0},
      '{7'd4,   1'b0, 1'b0, '0},
      '{7'd96,  1'b0, 1'b0, '0},
      '{7'd5,   1'b0, 1'b0, '0},
      '{7'd127, 1'b0, 1'b0, '0},
      '{7'd0,   1'b1, 1'b0, '0},
      '{7'd64,  1'b0, 1'b0, '0}
   };

   first_n_primes_sieve_unit #(.SIEVE_SIZE(SIEVE_SIZE)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_count_wanted (req_count_wanted),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prime_value  (rsp_prime_value),
      .rsp_is_last      (rsp_is_last),
      .rsp_out_of_room  (rsp_out_of_room)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic sieve_primes(input logic [COUNT_W-1:0] count);
      int             wanted;
      int             idx;
      int             number;
      int             mult;
      prime_beat_type beat;
      prime_beat_type found [$];
      wanted = (count > MAX_COUNT) ? MAX_COUNT : count;
      if (wanted != 0) begin
         for (idx = 0; idx < SIEVE_SIZE; idx++)
            sieve_marks[idx] = 1'b1;
         for (idx = 0; idx < SIEVE_SIZE && found.size() < wanted; idx++) begin
            if (sieve_marks[idx]) begin
               number     = idx + 2;
               beat.value = number[PRIME_W-1:0];
               beat.last  = 1'b0;
               beat.oor   = 1'b0;
               found.insert(found.size(), beat);
               for (mult = 2 * number - 2; mult < SIEVE_SIZE; mult += number)
                  sieve_marks[mult] = 1'b0;
            end
         end
         if (found.size() != 0) begin
            found[found.size()-1].last = 1'b1;
            if (found.size() < wanted)
               found[found.size()-1].oor = 1'b1;
         end
         foreach (found[i])
            pending_primes.insert(pending_primes.size(), found[i]);
      end
   endtask

   task automatic send_request(input stim_row_type row);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 15) == 0)
         req_calm = !req_calm;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_count_wanted = row.count;
      do @(posedge clock); while (!req_ready);
      if (row.typed) begin
         if (row.has_beat)
            pending_primes.insert(pending_primes.size(), row.beat);
      end else begin
         sieve_primes(row.count);
      end
      @(negedge clock);
   endtask

   initial begin
      stim_row_type row;
      int           pick;
      req_valid        = 1'b0;
      req_count_wanted = '0;
      reset            = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_request(directed_rows[i]);

      for (int i = 0; i < N_RANDOM; i++) begin
         pick = $urandom_range(0, 9);
         row  = '0;
         if (pick == 0)
            row.count = '0;
         else if (pick <= 2)
            row.count = COUNT_W'($urandom_range(64, 127));
         else
            row.count = COUNT_W'($urandom_range(1, 63));
         send_request(row);
      end
      req_valid = 1'b0;

      while (pending_primes.size() != 0)
         @(posedge clock);
      repeat (3000) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 23) == 0)
            rsp_calm = !rsp_calm;
         if (gap != 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      prime_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_primes.size() == 0) begin
            $display("%0t: unexpected beat: expected none, got prime %0d last %0b oor %0b",
                     $realtime, rsp_prime_value, rsp_is_last, rsp_out_of_room);
            mismatches++;
         end else begin
            want = pending_primes.pop_front();
            if (rsp_prime_value !== want.value) begin
               $display("%0t: prime_value: expected %0d, got %0d",
                        $realtime, want.value, rsp_prime_value);
               mismatches++;
            end
            if (rsp_is_last !== want.last) begin
               $display("%0t: is_last: expected %0b, got %0b",
                        $realtime, want.last, rsp_is_last);
               mismatches++;
            end
            if (rsp_out_of_room !== want.oor) begin
               $display("%0t: out_of_room: expected %0b, got %0b",
                        $realtime, want.oor, rsp_out_of_room);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("timeout, %0d beats still expected", pending_primes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
